// ===== rtl/tqvg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tqvg_pkg
// Shared types and constants of the tile quad vertex generator: tileset
// descriptor layout, stage payloads and vertex order codes.
// ----------------------------------------------------------------------------
package tqvg_pkg;

  // Stream widths (tdata padded to whole bytes)
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 96;

  // Field widths
  localparam int GRID_W  = 10;
  localparam int ID_W    = 16;
  localparam int BYTE_W  = 8;
  localparam int SCR_W   = 18;
  localparam int TEX_W   = 25;
  localparam int COUNT_W = 3;
  localparam int ENTRY_W = 64;

  // Register index of the tileset count; entry k sits at index k + 1
  localparam int REG_COUNT_IDX = 0;

  // Divider: 16-bit local id by 8-bit column count
  localparam int DIV_W     = ID_W;
  localparam int REM_W     = BYTE_W;
  localparam int DIV_BPS   = 4;
  localparam int DIV_STAGES = DIV_W / DIV_BPS;

  // Vertex order of the two triangles
  localparam logic [2:0] V_LT   = 3'd0;
  localparam logic [2:0] V_RT_A = 3'd1;
  localparam logic [2:0] V_LB_A = 3'd2;
  localparam logic [2:0] V_RT_B = 3'd3;
  localparam logic [2:0] V_RB   = 3'd4;
  localparam logic [2:0] V_LB_B = 3'd5;

  // Tileset descriptor, first id in the low bits
  typedef struct packed {
    logic [BYTE_W-1:0] key;
    logic [BYTE_W-1:0] margin;
    logic [BYTE_W-1:0] spacing;
    logic [BYTE_W-1:0] cols;
    logic [BYTE_W-1:0] tile_h;
    logic [BYTE_W-1:0] tile_w;
    logic [ID_W-1:0]   first_id;
  } tileset_t;

  // Payload after the table lookup
  typedef struct packed {
    logic [GRID_W-1:0] grid_x;
    logic [GRID_W-1:0] grid_y;
    logic [ID_W-1:0]   rel_id;
    logic [BYTE_W-1:0] tile_w;
    logic [BYTE_W-1:0] tile_h;
    logic [BYTE_W-1:0] cols;
    logic [BYTE_W-1:0] spacing;
    logic [BYTE_W-1:0] margin;
    logic [BYTE_W-1:0] key;
    logic              err;
  } lkup_t;

  // Payload after the division
  typedef struct packed {
    lkup_t            lk;
    logic [DIV_W-1:0] row;
    logic [REM_W-1:0] col;
  } divres_t;

  // Quad corners ready for emission
  typedef struct packed {
    logic [SCR_W-1:0]  left;
    logic [SCR_W-1:0]  right;
    logic [SCR_W-1:0]  top;
    logic [SCR_W-1:0]  bottom;
    logic [TEX_W-1:0]  tex_l;
    logic [TEX_W-1:0]  tex_r;
    logic [TEX_W-1:0]  tex_t;
    logic [TEX_W-1:0]  tex_b;
    logic [BYTE_W-1:0] key;
    logic              err;
  } quad_t;

endpackage
`default_nettype wire

// ===== rtl/tqvg_lookup.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tqvg_lookup
// Tileset table registers and the first pipeline stage: picks the last
// enabled entry whose first id is at most the tile id.
// ----------------------------------------------------------------------------
module tqvg_lookup #(
  parameter int NUM_TILESETS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [$clog2(NUM_TILESETS+1)-1:0]     cfg_index,
  input  logic [tqvg_pkg::ENTRY_W-1:0]          cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [tqvg_pkg::GRID_W-1:0]           in_grid_x,
  input  logic [tqvg_pkg::GRID_W-1:0]           in_grid_y,
  input  logic [tqvg_pkg::ID_W-1:0]             in_tile_id,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output tqvg_pkg::lkup_t                       out_data
);
  import tqvg_pkg::*;

  logic [COUNT_W-1:0] count_r;
  tileset_t           entry_r [NUM_TILESETS];
  logic               valid_r;
  lkup_t              data_r;
  logic               found;
  tileset_t           sel;
  logic               stage_ready;
  lkup_t              data_nxt;

  // Configuration writes; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < NUM_TILESETS; i++) begin
        entry_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (int'(cfg_index) == REG_COUNT_IDX) begin
        count_r <= cfg_wdata[COUNT_W-1:0];
      end
      for (int i = 0; i < NUM_TILESETS; i++) begin
        if (int'(cfg_index) == i + 1) begin
          entry_r[i] <= tileset_t'(cfg_wdata);
        end
      end
    end
  end

  // Table search, last match wins
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = 0; i < NUM_TILESETS; i++) begin
      if (i < int'(count_r) && in_tile_id >= entry_r[i].first_id) begin
        found = 1'b1;
        sel   = entry_r[i];
      end
    end
  end

  always_comb begin
    data_nxt.grid_x   = in_grid_x;
    data_nxt.grid_y   = in_grid_y;
    data_nxt.rel_id   = in_tile_id - sel.first_id;
    data_nxt.tile_w   = sel.tile_w;
    data_nxt.tile_h   = sel.tile_h;
    data_nxt.cols     = sel.cols;
    data_nxt.spacing  = sel.spacing;
    data_nxt.margin   = sel.margin;
    data_nxt.key      = sel.key;
    data_nxt.err      = !found || (sel.cols == '0);
  end

  assign stage_ready = !valid_r || out_ready;
  assign in_ready    = stage_ready;

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (stage_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

// ===== rtl/tqvg_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tqvg_divider
// Pipelined restoring divider: local id by column count, four quotient
// bits per stage. Gives atlas row (quotient) and column (remainder).
// ----------------------------------------------------------------------------
module tqvg_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tqvg_pkg::lkup_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tqvg_pkg::divres_t out_data
);
  import tqvg_pkg::*;

  logic             valid_r     [DIV_STAGES];
  lkup_t            pl_r        [DIV_STAGES];
  logic [REM_W-1:0] rem_r       [DIV_STAGES];
  logic [DIV_W-1:0] quot_r      [DIV_STAGES];
  logic             stage_ready [DIV_STAGES];
  logic             up_valid    [DIV_STAGES];
  lkup_t            pl_in       [DIV_STAGES];
  logic [REM_W-1:0] rem_nxt     [DIV_STAGES];
  logic [DIV_W-1:0] quot_nxt    [DIV_STAGES];

  // Ready chain, back to front; an empty stage always takes data
  always_comb begin
    for (int s = DIV_STAGES - 1; s >= 0; s--) begin
      if (s == DIV_STAGES - 1) begin
        stage_ready[s] = !valid_r[s] || out_ready;
      end else begin
        stage_ready[s] = !valid_r[s] || stage_ready[s+1];
      end
    end
  end

  // Division steps of each stage
  always_comb begin
    logic [REM_W:0]   trial;
    logic [REM_W-1:0] r;
    logic [DIV_W-1:0] q;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        up_valid[s] = in_valid;
        pl_in[s]    = in_data;
        r           = '0;
        q           = '0;
      end else begin
        up_valid[s] = valid_r[s-1];
        pl_in[s]    = pl_r[s-1];
        r           = rem_r[s-1];
        q           = quot_r[s-1];
      end
      for (int b = 0; b < DIV_BPS; b++) begin
        trial = {r, pl_in[s].rel_id[DIV_W - 1 - s * DIV_BPS - b]};
        if (trial >= {1'b0, pl_in[s].cols}) begin
          trial = trial - {1'b0, pl_in[s].cols};
          q     = {q[DIV_W-2:0], 1'b1};
        end else begin
          q     = {q[DIV_W-2:0], 1'b0};
        end
        r = trial[REM_W-1:0];
      end
      rem_nxt[s]  = r;
      quot_nxt[s] = q;
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        valid_r[s] <= 1'b0;
      end
    end else begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        if (stage_ready[s]) begin
          valid_r[s] <= up_valid[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (stage_ready[s] && up_valid[s]) begin
        pl_r[s]   <= pl_in[s];
        rem_r[s]  <= rem_nxt[s];
        quot_r[s] <= quot_nxt[s];
      end
    end
  end

  assign in_ready     = stage_ready[0];
  assign out_valid    = valid_r[DIV_STAGES-1];
  assign out_data.lk  = pl_r[DIV_STAGES-1];
  assign out_data.row = quot_r[DIV_STAGES-1];
  assign out_data.col = rem_r[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/tqvg_coord.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tqvg_coord
// Two stages: products of grid positions with tile size and of atlas
// positions with tile pitch, then the edge sums that give the quad corners.
// ----------------------------------------------------------------------------
module tqvg_coord (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tqvg_pkg::divres_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tqvg_pkg::quad_t   out_data
);
  import tqvg_pkg::*;

  localparam int PITCH_W = BYTE_W + 1;
  localparam int PU_W    = SCR_W - 1;

  // Multiply stage registers
  logic              valid_a_r;
  logic [SCR_W-1:0]  px_r;
  logic [SCR_W-1:0]  py_r;
  logic [PU_W-1:0]   pu_r;
  logic [TEX_W-1:0]  pv_r;
  logic [BYTE_W-1:0] w_r;
  logic [BYTE_W-1:0] h_r;
  logic [BYTE_W-1:0] mg_r;
  logic [BYTE_W-1:0] key_r;
  logic              err_r;

  // Sum stage registers
  logic              valid_b_r;
  quad_t             quad_r;

  logic              ready_a;
  logic              ready_b;
  logic [PITCH_W-1:0] pitch_u;
  logic [PITCH_W-1:0] pitch_v;
  logic [SCR_W-1:0]  tex_l_s;
  logic [TEX_W-1:0]  tex_t_s;
  quad_t             quad_nxt;

  assign ready_b  = !valid_b_r || out_ready;
  assign ready_a  = !valid_a_r || ready_b;
  assign in_ready = ready_a;

  assign pitch_u = PITCH_W'(in_data.lk.tile_w) + PITCH_W'(in_data.lk.spacing);
  assign pitch_v = PITCH_W'(in_data.lk.tile_h) + PITCH_W'(in_data.lk.spacing);

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else begin
      if (ready_a) begin
        valid_a_r <= in_valid;
      end
      if (ready_b) begin
        valid_b_r <= valid_a_r;
      end
    end
  end

  // Products
  always_ff @(posedge clk) begin
    if (ready_a && in_valid) begin
      px_r  <= SCR_W'(in_data.lk.grid_x) * SCR_W'(in_data.lk.tile_w);
      py_r  <= SCR_W'(in_data.lk.grid_y) * SCR_W'(in_data.lk.tile_h);
      pu_r  <= PU_W'(in_data.col) * PU_W'(pitch_u);
      pv_r  <= TEX_W'(in_data.row) * TEX_W'(pitch_v);
      w_r   <= in_data.lk.tile_w;
      h_r   <= in_data.lk.tile_h;
      mg_r  <= in_data.lk.margin;
      key_r <= in_data.lk.key;
      err_r <= in_data.lk.err;
    end
  end

  // Corner sums
  always_comb begin
    tex_l_s         = SCR_W'(pu_r) + SCR_W'(mg_r);
    tex_t_s         = pv_r + TEX_W'(mg_r);
    quad_nxt.left   = px_r;
    quad_nxt.right  = px_r + SCR_W'(w_r);
    quad_nxt.top    = py_r;
    quad_nxt.bottom = py_r + SCR_W'(h_r);
    quad_nxt.tex_l  = TEX_W'(tex_l_s);
    quad_nxt.tex_r  = TEX_W'(tex_l_s + SCR_W'(w_r));
    quad_nxt.tex_t  = tex_t_s;
    quad_nxt.tex_b  = tex_t_s + TEX_W'(h_r);
    quad_nxt.key    = key_r;
    quad_nxt.err    = err_r;
  end

  always_ff @(posedge clk) begin
    if (ready_b && valid_a_r) begin
      quad_r <= quad_nxt;
    end
  end

  assign out_valid = valid_b_r;
  assign out_data  = quad_r;

endmodule
`default_nettype wire

// ===== rtl/tqvg_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tqvg_emit
// Holds one quad and walks its six vertices into the output register;
// a failed lookup gives a single error result instead.
// ----------------------------------------------------------------------------
module tqvg_emit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tqvg_pkg::quad_t                  in_data,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tqvg_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tuser,
  output logic                             out_tlast
);
  import tqvg_pkg::*;

  localparam int PAD_W = OUT_TDATA_W - 2 * SCR_W - 2 * TEX_W - BYTE_W;

  logic              buf_valid_r;
  quad_t             buf_r;
  logic [2:0]        vidx_r;
  logic              out_valid_r;
  logic [SCR_W-1:0]  vx_r;
  logic [SCR_W-1:0]  vy_r;
  logic [TEX_W-1:0]  tu_r;
  logic [TEX_W-1:0]  tv_r;
  logic [BYTE_W-1:0] key_r;
  logic              err_r;
  logic              last_r;

  logic              out_load;
  logic              buf_last;
  logic              is_right;
  logic              is_bottom;
  logic              take;
  logic              buf_valid_nxt;
  logic [2:0]        vidx_nxt;

  assign out_load = buf_valid_r && (!out_valid_r || out_tready);
  assign buf_last = buf_r.err || (vidx_r == V_LB_B);
  assign in_ready = !buf_valid_r || (out_load && buf_last);
  assign take     = in_valid && in_ready;

  // Corner selection for the current vertex
  always_comb begin
    case (vidx_r)
      V_LT:    begin is_right = 1'b0; is_bottom = 1'b0; end
      V_RT_A:  begin is_right = 1'b1; is_bottom = 1'b0; end
      V_LB_A:  begin is_right = 1'b0; is_bottom = 1'b1; end
      V_RT_B:  begin is_right = 1'b1; is_bottom = 1'b0; end
      V_RB:    begin is_right = 1'b1; is_bottom = 1'b1; end
      V_LB_B:  begin is_right = 1'b0; is_bottom = 1'b1; end
      default: begin is_right = 1'b0; is_bottom = 1'b0; end
    endcase
  end

  // Quad buffer and vertex counter
  always_comb begin
    buf_valid_nxt = buf_valid_r;
    vidx_nxt      = vidx_r;
    if (take) begin
      buf_valid_nxt = 1'b1;
      vidx_nxt      = V_LT;
    end else if (out_load && buf_last) begin
      buf_valid_nxt = 1'b0;
    end else if (out_load) begin
      vidx_nxt      = vidx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      vidx_r      <= V_LT;
      out_valid_r <= 1'b0;
    end else begin
      buf_valid_r <= buf_valid_nxt;
      vidx_r      <= vidx_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      buf_r <= in_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (buf_r.err) begin
        vx_r  <= '0;
        vy_r  <= '0;
        tu_r  <= '0;
        tv_r  <= '0;
        key_r <= '0;
      end else begin
        vx_r  <= is_right  ? buf_r.right  : buf_r.left;
        vy_r  <= is_bottom ? buf_r.bottom : buf_r.top;
        tu_r  <= is_right  ? buf_r.tex_r  : buf_r.tex_l;
        tv_r  <= is_bottom ? buf_r.tex_b  : buf_r.tex_t;
        key_r <= buf_r.key;
      end
      err_r  <= buf_r.err;
      last_r <= buf_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, key_r, tv_r, tu_r, vy_r, vx_r};
  assign out_tuser  = err_r;
  assign out_tlast  = last_r;

endmodule
`default_nettype wire

// ===== rtl/tile_quad_vertex_generator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tile_quad_vertex_generator_top
// Turns map tiles into two textured triangles (six vertices) per tile.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream carries one tile per transfer (grid cell and global id).
//   Output stream gives six vertex transfers per tile, tlast on the sixth;
//   a tile with no matching tileset, or one with zero columns, gives a
//   single transfer with tuser set and tlast set, all data zero.
//   Tileset table is written through the cfg port while the block is idle.
// Timing:
//   First vertex passes through lookup, four divider stages, multiply,
//   corner sums, quad buffer and output register.
//   Tiles enter every cycle until the pipeline fills; sustained rate is set
//   by the single output channel, which carries one vertex per cycle while
//   the receiver accepts, six vertices per tile (one for error tiles).
// Reset and stall:
//   Reset clears the pipeline and the tileset table (count zero).
//   When the receiver stalls, the output holds, the pipeline fills and
//   in_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module tile_quad_vertex_generator_top #(
  parameter int NUM_TILESETS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration
  input  logic                              cfg_we,
  input  logic [$clog2(NUM_TILESETS+1)-1:0] cfg_index,
  input  logic [tqvg_pkg::ENTRY_W-1:0]      cfg_wdata,
  // Tile input
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tqvg_pkg::IN_TDATA_W-1:0]   in_tdata,   // grid_x, grid_y, tile_id
  // Vertex output
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tqvg_pkg::OUT_TDATA_W-1:0]  out_tdata,  // vertex_x, vertex_y, texel_u,
                                                        // texel_v, tex_key
  output logic                              out_tuser,  // lookup_error
  output logic                              out_tlast   // last_vertex
);
  import tqvg_pkg::*;

  logic    lk_valid;
  logic    lk_ready;
  lkup_t   lk_data;
  logic    dv_valid;
  logic    dv_ready;
  divres_t dv_data;
  logic    qd_valid;
  logic    qd_ready;
  quad_t   qd_data;

  tqvg_lookup #(
    .NUM_TILESETS (NUM_TILESETS)
  ) u_lookup (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_grid_x  (in_tdata[GRID_W-1:0]),
    .in_grid_y  (in_tdata[2*GRID_W-1:GRID_W]),
    .in_tile_id (in_tdata[2*GRID_W+ID_W-1:2*GRID_W]),
    .out_valid  (lk_valid),
    .out_ready  (lk_ready),
    .out_data   (lk_data)
  );

  tqvg_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lk_valid),
    .in_ready  (lk_ready),
    .in_data   (lk_data),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_data  (dv_data)
  );

  tqvg_coord u_coord (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_data   (dv_data),
    .out_valid (qd_valid),
    .out_ready (qd_ready),
    .out_data  (qd_data)
  );

  tqvg_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (qd_valid),
    .in_ready   (qd_ready),
    .in_data    (qd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tile_quad_vertex_generator_top. A scoreboard keeps
// its own copy of the tileset table, predicts the six vertices (or the single
// lookup error) of every tile that enters, and compares each vertex transfer
// field by field. The run goes through directed table settings, then random
// tables with random tiles, under bursty input and a varying output stall.
// ----------------------------------------------------------------------------
module testbench;
  import tqvg_pkg::*;

  localparam int NUM_TILESETS = 4;
  localparam int CFG_IDX_W    = $clog2(NUM_TILESETS + 1);
  localparam int ENTRY0_IDX   = REG_COUNT_IDX + 1;
  localparam int UNUSED_IDX   = NUM_TILESETS + 1;   // first index with no register
  localparam int QUIET_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 16;

  // Output field offsets in out_tdata
  localparam int VY_LSB  = SCR_W;
  localparam int TU_LSB  = 2 * SCR_W;
  localparam int TV_LSB  = TU_LSB + TEX_W;
  localparam int KEY_LSB = TV_LSB + TEX_W;

  typedef struct packed {
    logic [SCR_W-1:0]  vx;
    logic [SCR_W-1:0]  vy;
    logic [TEX_W-1:0]  tu;
    logic [TEX_W-1:0]  tv;
    logic [BYTE_W-1:0] key;
    logic              err;
    logic              last;
  } vertex_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tileset table copy, vertex prediction and checking
  // --------------------------------------------------------------------------
  class quad_checker;
    tileset_t    sets [NUM_TILESETS];
    logic [2:0]  set_count;
    vertex_t     vertex_q [$];
    int          errors;
    int          n_tiles;
    int          n_vertices;
    int          n_lookup_fails;

    function new();
      foreach (sets[i]) sets[i] = '0;
      set_count = '0;
      errors = 0;
      n_tiles = 0;
      n_vertices = 0;
      n_lookup_fails = 0;
    endfunction

    function void write_reg(int unsigned idx, logic [ENTRY_W-1:0] val);
      if (idx == REG_COUNT_IDX) begin
        set_count = val[COUNT_W-1:0];
      end else if (idx < ENTRY0_IDX + NUM_TILESETS) begin
        sets[idx - ENTRY0_IDX] = tileset_t'(val);
      end
    endfunction

    function void add_vertex(int unsigned x, int unsigned y, int unsigned u, int unsigned v,
                             logic [BYTE_W-1:0] key, bit last);
      vertex_t vtx;
      vtx = '0;
      vtx.vx = SCR_W'(x);
      vtx.vy = SCR_W'(y);
      vtx.tu = TEX_W'(u);
      vtx.tv = TEX_W'(v);
      vtx.key = key;
      vtx.last = last;
      vertex_q.push_back(vtx);
    endfunction

    // Table lookup and quad corners for one accepted tile
    function void note_tile(logic [GRID_W-1:0] gx, logic [GRID_W-1:0] gy,
                            logic [ID_W-1:0] id);
      tileset_t    hit;
      bit          found;
      vertex_t     fail_v;
      int unsigned n_on, w, h, cols, sp, lid, left, top, right, bottom, ul, ut, ur, ub;
      n_tiles++;
      n_on = (set_count > NUM_TILESETS) ? NUM_TILESETS : 32'(set_count);
      found = 1'b0;
      hit = '0;
      // last enabled entry in table order wins
      for (int i = 0; i < n_on; i++) begin
        if (id >= sets[i].first_id) begin
          hit = sets[i];
          found = 1'b1;
        end
      end
      if (!found || hit.cols == 0) begin
        fail_v = '0;
        fail_v.err = 1'b1;
        fail_v.last = 1'b1;
        vertex_q.push_back(fail_v);
        n_lookup_fails++;
        return;
      end
      w = 32'(hit.tile_w);
      h = 32'(hit.tile_h);
      cols = 32'(hit.cols);
      sp = 32'(hit.spacing);
      lid = 32'(id) - 32'(hit.first_id);
      left = 32'(gx) * w;
      top = 32'(gy) * h;
      right = left + w;
      bottom = top + h;
      ul = (lid % cols) * (w + sp) + 32'(hit.margin);
      ut = (lid / cols) * (h + sp) + 32'(hit.margin);
      ur = ul + w;
      ub = ut + h;
      add_vertex(left,  top,    ul, ut, hit.key, 1'b0);
      add_vertex(right, top,    ur, ut, hit.key, 1'b0);
      add_vertex(left,  bottom, ul, ub, hit.key, 1'b0);
      add_vertex(right, top,    ur, ut, hit.key, 1'b0);
      add_vertex(right, bottom, ur, ub, hit.key, 1'b0);
      add_vertex(left,  bottom, ul, ub, hit.key, 1'b1);
    endfunction

    function void mismatch(string field, longint unsigned want, longint unsigned got);
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      errors++;
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t want;
      if (vertex_q.size() == 0) begin
        $error("vertex transfer with nothing expected");
        errors++;
        return;
      end
      want = vertex_q.pop_front();
      n_vertices++;
      if (got.vx !== want.vx)     mismatch("vertex_x", 64'(want.vx), 64'(got.vx));
      if (got.vy !== want.vy)     mismatch("vertex_y", 64'(want.vy), 64'(got.vy));
      if (got.tu !== want.tu)     mismatch("texel_u", 64'(want.tu), 64'(got.tu));
      if (got.tv !== want.tv)     mismatch("texel_v", 64'(want.tv), 64'(got.tv));
      if (got.key !== want.key)   mismatch("tex_key", 64'(want.key), 64'(got.key));
      if (got.err !== want.err)   mismatch("lookup_error", 64'(want.err), 64'(got.err));
      if (got.last !== want.last) mismatch("last_vertex", 64'(want.last), 64'(got.last));
    endfunction

    function int pending();
      return vertex_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and signals
  // --------------------------------------------------------------------------
  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [ENTRY_W-1:0]     cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // grid_x, grid_y, tile_id
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // vertex_x, vertex_y, texel_u, texel_v, tex_key
  logic                   out_tuser;   // lookup_error
  logic                   out_tlast;   // last_vertex

  quad_checker sb = new();
  int          quiet_cycles = 0;
  int          n_settings;

  tile_quad_vertex_generator_top #(
    .NUM_TILESETS(NUM_TILESETS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor: note accepted tiles, check vertices, watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    vertex_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_tile(in_tdata[GRID_W-1:0], in_tdata[2*GRID_W-1:GRID_W],
                     in_tdata[2*GRID_W+ID_W-1:2*GRID_W]);
      end
      if (out_tvalid && out_tready) begin
        got.vx = out_tdata[SCR_W-1:0];
        got.vy = out_tdata[VY_LSB +: SCR_W];
        got.tu = out_tdata[TU_LSB +: TEX_W];
        got.tv = out_tdata[TV_LSB +: TEX_W];
        got.key = out_tdata[KEY_LSB +: BYTE_W];
        got.err = out_tuser;
        got.last = out_tlast;
        sb.check_vertex(got);
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d vertices outstanding",
               QUIET_LIMIT, sb.pending());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall pattern: a random stall mode, picked anew for each run of cycles
  // --------------------------------------------------------------------------
  initial begin
    int mode;
    int step;
    out_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      step = 0;
      repeat ($urandom_range(20, 80)) begin
        @(negedge clk);
        case (mode)
          0: begin
            out_tready <= 1'b1;
          end
          1: begin
            out_tready <= ($urandom_range(0, 1) != 0);
          end
          2: begin
            out_tready <= ($urandom_range(0, 7) != 0);
          end
          default: begin
            out_tready <= ((step % 7) < 2);
          end
        endcase
        step++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  function automatic logic [ENTRY_W-1:0] pack_set(int first, int w, int h, int cols,
                                                  int sp, int mg, int key);
    tileset_t s;
    s.first_id = ID_W'(first);
    s.tile_w = BYTE_W'(w);
    s.tile_h = BYTE_W'(h);
    s.cols = BYTE_W'(cols);
    s.spacing = BYTE_W'(sp);
    s.margin = BYTE_W'(mg);
    s.key = BYTE_W'(key);
    return s;
  endfunction

  // cfg_we stays high across back-to-back writes; close_cfg drops it
  task automatic write_reg(input int unsigned idx, input logic [ENTRY_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_wdata <= val;
    sb.write_reg(idx, val);
  endtask

  task automatic close_cfg();
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // One tile transfer; tvalid is left high for a following tile
  task automatic send_tile(input int unsigned gx, input int unsigned gy,
                           input int unsigned id);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TDATA_W-2*GRID_W-ID_W){1'b0}}, ID_W'(id), GRID_W'(gy), GRID_W'(gx)};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Hold off the sender until every predicted vertex has been seen
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Random table followed by a batch of tiles aimed mostly at enabled entries
  task automatic random_phase(input int n_items, input bit steady);
    tileset_t            e [NUM_TILESETS];
    logic [ENTRY_W-1:0]  w;
    int                  cnt, n_on, j, pick;
    int unsigned         id;
    cnt = ($urandom_range(0, 9) < 7) ? $urandom_range(1, NUM_TILESETS) : $urandom_range(0, 7);
    n_on = (cnt > NUM_TILESETS) ? NUM_TILESETS : cnt;
    write_reg(REG_COUNT_IDX, ENTRY_W'(cnt));
    for (int k = 0; k < NUM_TILESETS; k++) begin
      w = {$urandom, $urandom};
      if ($urandom_range(0, 1)) w[ID_W-1:0] = ID_W'($urandom_range(0, 2000));
      if ($urandom_range(0, 7) == 0) w[39:32] = '0;   // zero column count
      e[k] = tileset_t'(w);
      write_reg(ENTRY0_IDX + k, w);
    end
    if ($urandom_range(0, 3) == 0) write_reg($urandom_range(UNUSED_IDX, 7), {$urandom, $urandom});
    close_cfg();
    j = 0;
    while (j < n_items) begin
      repeat ($urandom_range(1, 8)) begin
        if (j < n_items) begin
          if (n_on > 0 && $urandom_range(0, 4) != 0) begin
            pick = $urandom_range(0, n_on - 1);
            id = 32'(e[pick].first_id) + $urandom_range(0, 700);
            if (id > 16'hFFFF) id = 16'hFFFF;
          end else begin
            id = $urandom_range(0, 16'hFFFF);
          end
          send_tile($urandom_range(0, 1023), $urandom_range(0, 1023), id);
          j++;
        end
      end
      if (!steady) pause($urandom_range(0, 6));
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    n_settings = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty table after reset: every tile fails the lookup
    send_tile(0, 0, 0);
    send_tile(1023, 1023, 16'hFFFF);
    drain();

    // Later matching entry wins over earlier ones; zero columns fail
    write_reg(REG_COUNT_IDX, ENTRY_W'(NUM_TILESETS));
    write_reg(ENTRY0_IDX + 0, pack_set(0, 16, 16, 8, 1, 2, 8'h11));
    write_reg(ENTRY0_IDX + 1, pack_set(100, 255, 255, 255, 255, 255, 255));
    write_reg(ENTRY0_IDX + 2, pack_set(200, 8, 12, 0, 3, 4, 8'h22));
    write_reg(ENTRY0_IDX + 3, pack_set(16'hFFFF, 1, 1, 1, 0, 0, 8'h80));
    close_cfg();
    send_tile(0, 0, 0);
    send_tile(1023, 1023, 99);
    send_tile(1023, 1023, 100);
    send_tile(5, 7, 199);
    send_tile(3, 3, 200);
    send_tile(3, 3, 16'hFFFE);
    send_tile(1023, 0, 16'hFFFF);
    drain();

    // Count above table size, maximal fields, writes to indexes with no register
    write_reg(REG_COUNT_IDX, ENTRY_W'(7));
    write_reg(ENTRY0_IDX + 0, pack_set(0, 255, 255, 255, 255, 255, 255));
    write_reg(ENTRY0_IDX + 1, pack_set(16'h8000, 255, 255, 1, 255, 255, 8'hA5));
    write_reg(ENTRY0_IDX + 2, pack_set(16'hFFFF, 0, 0, 1, 0, 0, 0));
    write_reg(ENTRY0_IDX + 3, {ENTRY_W{1'b1}});
    write_reg(UNUSED_IDX, '0);
    write_reg(7, {ENTRY_W{1'b1}});
    close_cfg();
    send_tile(0, 0, 0);
    send_tile(1023, 1023, 16'h7FFF);
    send_tile(1023, 0, 16'h8000);
    send_tile(0, 1023, 16'hFFFE);
    send_tile(1023, 1023, 16'hFFFF);
    send_tile(512, 511, 16'h1234);
    drain();

    // Single enabled entry: matching later entries are ignored
    write_reg(REG_COUNT_IDX, ENTRY_W'(1));
    write_reg(ENTRY0_IDX + 0, pack_set(10, 32, 24, 5, 2, 1, 8'h3C));
    close_cfg();
    send_tile(2, 9, 9);
    send_tile(2, 9, 10);
    send_tile(1, 1, 16'hFFFF);
    pause(3);
    send_tile(700, 300, 37);
    drain();

    // Random tables and tiles; every third phase without sender gaps
    for (int p = 0; p < 8; p++) begin
      random_phase(18, (p % 3) == 1);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d tiles over %0d table settings under random input gaps and stalls.",
             sb.n_tiles, n_settings);
    $display("Checked %0d vertex transfers, %0d of them lookup failures; %0d mismatches.",
             sb.n_vertices, sb.n_lookup_fails, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
